[hw/rtl/qact_pkg.sv]
// Shared types and constants for the int8 quantized activation block.
// Used by every module under hw/rtl; no dependencies of its own.
`default_nettype none
package qact_pkg;

   localparam int MAG_W  = 40;   // dequantized magnitude, Q24
   localparam int U_W    = 29;   // exponent argument, Q24 (read as Q30)
   localparam int T_W    = 31;   // exponential terms, Q30, up to 1.0
   localparam int DEN_W  = 32;   // 1.0 + e in Q30, up to 2.0
   localparam int QUO_W  = 25;   // divider quotient, Q24, up to 1.0
   localparam int NUM_W  = 55;   // divider dividend
   localparam int INV_W  = 32;
   localparam int IDX_W  = 3;

   localparam logic [1:0] MODE_RELU  = 2'd0;
   localparam logic [1:0] MODE_RELU6 = 2'd1;
   localparam logic [1:0] MODE_TANH  = 2'd2;
   localparam logic [1:0] MODE_SIGM  = 2'd3;

   localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [IDX_W-1:0] REG_IN_ZP   = 3'd1;
   localparam logic [IDX_W-1:0] REG_IN_SCL  = 3'd2;
   localparam logic [IDX_W-1:0] REG_OUT_ZP  = 3'd3;
   localparam logic [IDX_W-1:0] REG_OUT_INV = 3'd4;

   localparam logic [T_W-1:0]   ONE_Q30     = 31'h4000_0000;
   localparam logic [MAG_W-1:0] SIX_Q24     = 40'd6 << 24;
   localparam logic [MAG_W-1:0] TANH_CLAMP  = 40'd12 << 24;
   localparam logic [MAG_W-1:0] SIGM_CLAMP  = 40'd24 << 24;
   localparam logic [QUO_W-1:0] ONE_Q24     = 25'h100_0000;

   // reciprocal constants: floor(x/3) = (x*RCP3) >> 31, floor(x/5) = (x*RCP5) >> 33
   localparam logic [29:0] RCP3 = 30'd715827883;
   localparam logic [30:0] RCP5 = 31'd1717986919;

   // sideband that travels with each request
   typedef struct packed {
      logic [1:0]       mode;
      logic             neg;
      logic [MAG_W-1:0] lin;
   } side_type;

endpackage
`default_nettype wire

[hw/rtl/qact_exp.sv]
// exp(-u) pipeline: six Horner steps (multiply stage, divide stage) and six squarings.
// Depends on qact_pkg.
`default_nettype none
module qact_exp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire qact_pkg::side_type          in_side,
   input  wire logic [qact_pkg::U_W-1:0]    in_u,
   output logic                             out_valid,
   output qact_pkg::side_type               out_side,
   output logic [qact_pkg::T_W-1:0]         out_e
);

   localparam int U_W = qact_pkg::U_W;
   localparam int T_W = qact_pkg::T_W;

   logic                a_v_ff    [0:5];
   qact_pkg::side_type  a_side_ff [0:5];
   logic [U_W-1:0]      a_s_ff    [0:5];
   logic [U_W-1:0]      a_x_ff    [0:5];
   logic                b_v_ff    [0:5];
   qact_pkg::side_type  b_side_ff [0:5];
   logic [U_W-1:0]      b_s_ff    [0:5];
   logic [T_W-1:0]      b_t_ff    [0:5];
   logic                q_v_ff    [0:5];
   qact_pkg::side_type  q_side_ff [0:5];
   logic [T_W-1:0]      q_t_ff    [0:5];

   genvar j;
   generate
      for (j = 0; j < 6; j++) begin : g_horner
         localparam int K = 6 - j;
         logic               v_src;
         qact_pkg::side_type side_src;
         logic [U_W-1:0]     s_src;
         logic [T_W-1:0]     t_src;
         logic [59:0]        prod;
         logic [U_W-1:0]     x_in;
         logic [U_W-1:0]     qk;

         if (j == 0) begin : g_first
            assign v_src    = in_valid;
            assign side_src = in_side;
            assign s_src    = in_u;
            assign t_src    = qact_pkg::ONE_Q30;
         end else begin : g_next
            assign v_src    = b_v_ff[j-1];
            assign side_src = b_side_ff[j-1];
            assign s_src    = b_s_ff[j-1];
            assign t_src    = b_t_ff[j-1];
         end

         assign prod = 60'(s_src) * 60'(t_src);
         assign x_in = prod[58:30];

         if (K == 6) begin : g_k6
            logic [58:0] p3;
            assign p3 = 59'(a_x_ff[j] >> 1) * 59'(qact_pkg::RCP3);
            assign qk = U_W'(p3[58:31]);
         end else if (K == 5) begin : g_k5
            logic [59:0] p5;
            assign p5 = 60'(a_x_ff[j]) * 60'(qact_pkg::RCP5);
            assign qk = p5[33 +: U_W-2] == '0 ? '0 : U_W'(p5[59:33]);
         end else if (K == 3) begin : g_k3
            logic [58:0] p3;
            assign p3 = 59'(a_x_ff[j]) * 59'(qact_pkg::RCP3);
            assign qk = p3[31 +: U_W-1] == '0 ? '0 : U_W'(p3[58:31]);
         end else if (K == 4) begin : g_k4
            assign qk = a_x_ff[j] >> 2;
         end else if (K == 2) begin : g_k2
            assign qk = a_x_ff[j] >> 1;
         end else begin : g_k1
            assign qk = a_x_ff[j];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               a_v_ff[j] <= 1'b0;
               b_v_ff[j] <= 1'b0;
            end else if (en) begin
               a_v_ff[j] <= v_src;
               b_v_ff[j] <= a_v_ff[j];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               a_side_ff[j] <= side_src;
               a_s_ff[j]    <= s_src;
               a_x_ff[j]    <= x_in;
               b_side_ff[j] <= a_side_ff[j];
               b_s_ff[j]    <= a_s_ff[j];
               b_t_ff[j]    <= qact_pkg::ONE_Q30 - T_W'(qk);
            end
         end
      end

      for (j = 0; j < 6; j++) begin : g_square
         logic               v_src;
         qact_pkg::side_type side_src;
         logic [T_W-1:0]     t_src;
         logic [61:0]        sq;

         if (j == 0) begin : g_first
            assign v_src    = b_v_ff[5];
            assign side_src = b_side_ff[5];
            assign t_src    = b_t_ff[5];
         end else begin : g_next
            assign v_src    = q_v_ff[j-1];
            assign side_src = q_side_ff[j-1];
            assign t_src    = q_t_ff[j-1];
         end

         assign sq = 62'(t_src) * 62'(t_src) + 62'(32'h2000_0000);

         always_ff @(posedge clock) begin
            if (reset) begin
               q_v_ff[j] <= 1'b0;
            end else if (en) begin
               q_v_ff[j] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               q_side_ff[j] <= side_src;
               q_t_ff[j]    <= sq[60:30];
            end
         end
      end
   endgenerate

   assign out_valid = q_v_ff[5];
   assign out_side  = q_side_ff[5];
   assign out_e     = q_t_ff[5];

endmodule
`default_nettype wire

[hw/rtl/qact_div.sv]
// Restoring divider, one quotient bit per pipeline stage.
// Depends on qact_pkg.
`default_nettype none
module qact_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire qact_pkg::side_type           in_side,
   input  wire logic [qact_pkg::DEN_W-1:0]   in_rem,
   input  wire logic [qact_pkg::QUO_W-1:0]   in_low,
   input  wire logic [qact_pkg::DEN_W-1:0]   in_den,
   output logic                              out_valid,
   output qact_pkg::side_type                out_side,
   output logic [qact_pkg::QUO_W-1:0]        out_quo
);

   localparam int DEN_W = qact_pkg::DEN_W;
   localparam int QUO_W = qact_pkg::QUO_W;

   logic                v_ff    [0:QUO_W-1];
   qact_pkg::side_type  side_ff [0:QUO_W-1];
   logic [DEN_W-1:0]    rem_ff  [0:QUO_W-1];
   logic [QUO_W-1:0]    low_ff  [0:QUO_W-1];
   logic [DEN_W-1:0]    den_ff  [0:QUO_W-1];
   logic [QUO_W-1:0]    quo_ff  [0:QUO_W-1];

   genvar i;
   generate
      for (i = 0; i < QUO_W; i++) begin : g_bit
         logic               v_src;
         qact_pkg::side_type side_src;
         logic [DEN_W-1:0]   rem_src;
         logic [QUO_W-1:0]   low_src;
         logic [DEN_W-1:0]   den_src;
         logic [QUO_W-1:0]   quo_src;
         logic [DEN_W:0]     trial;
         logic [DEN_W:0]     diff;
         logic               fits;

         if (i == 0) begin : g_first
            assign v_src    = in_valid;
            assign side_src = in_side;
            assign rem_src  = in_rem;
            assign low_src  = in_low;
            assign den_src  = in_den;
            assign quo_src  = '0;
         end else begin : g_next
            assign v_src    = v_ff[i-1];
            assign side_src = side_ff[i-1];
            assign rem_src  = rem_ff[i-1];
            assign low_src  = low_ff[i-1];
            assign den_src  = den_ff[i-1];
            assign quo_src  = quo_ff[i-1];
         end

         assign trial = {rem_src, low_src[QUO_W-1]};
         assign diff  = trial - {1'b0, den_src};
         assign fits  = trial >= {1'b0, den_src};

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (en) begin
               v_ff[i] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[i] <= side_src;
               rem_ff[i]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               low_ff[i]  <= {low_src[QUO_W-2:0], 1'b0};
               den_ff[i]  <= den_src;
               quo_ff[i]  <= {quo_src[QUO_W-2:0], fits};
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

[hw/rtl/qact_requant.sv]
// Requantization: multiply by the reciprocal output scale, round, offset, saturate.
// Holds the output register of the block. Depends on qact_pkg.
`default_nettype none
module qact_requant (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic                         in_neg,
   input  wire logic [qact_pkg::MAG_W-1:0]   in_mag,
   input  wire logic [qact_pkg::INV_W-1:0]   inv_scale,
   input  wire logic signed [7:0]            out_offset,
   output logic                              out_valid,
   output logic signed [7:0]                 out_sample
);

   logic        m_v_ff;
   logic        m_neg_ff;
   logic [47:0] m_hp_ff;
   logic [55:0] m_lp_ff;
   logic        r_v_ff;
   logic        r_neg_ff;
   logic [7:0]  r_q_ff;
   logic        o_v_ff;
   logic signed [7:0] o_sample_ff;

   logic [48:0]       hi;
   logic [48:0]       rnd;
   logic [7:0]        q_in;
   logic signed [9:0] signed_q;
   logic signed [9:0] sum;
   logic signed [7:0] sat_in;

   assign hi   = 49'(m_hp_ff) + 49'(m_lp_ff[55:24]);
   assign rnd  = hi + 49'(16'h8000);
   assign q_in = (rnd[48:16] > 33'd255) ? 8'd255 : rnd[23:16];

   assign signed_q = r_neg_ff ? -$signed({2'b00, r_q_ff}) : $signed({2'b00, r_q_ff});
   assign sum      = signed_q + 10'(out_offset);

   always_comb begin
      if (sum > 10'sd127) begin
         sat_in = 8'sd127;
      end else if (sum < -10'sd128) begin
         sat_in = -8'sd128;
      end else begin
         sat_in = sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= in_valid;
         r_v_ff <= m_v_ff;
         o_v_ff <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_neg_ff    <= in_neg;
         m_hp_ff     <= 48'(in_mag[39:24]) * 48'(inv_scale);
         m_lp_ff     <= 56'(in_mag[23:0]) * 56'(inv_scale);
         r_neg_ff    <= m_neg_ff;
         r_q_ff      <= q_in;
         o_sample_ff <= sat_in;
      end
   end

   assign out_valid  = o_v_ff;
   assign out_sample = o_sample_ff;

endmodule
`default_nettype wire

[hw/rtl/quantized_activation_int8.sv]
// Int8 quantized activation unit (relu, relu6, tanh, logistic), top level.
// Uses qact_pkg, qact_exp, qact_div and qact_requant.
//
// Usage:
//   req_* carries one signed int8 sample per request (valid/ready).
//   rsp_* returns one activated, requantized int8 sample per request, in order.
//   csr_* writes the five settings registers (index 0..4); write only while idle.
// Throughput: one sample per cycle, sustained, in every mode, while rsp_ready does not stall the output.
// The pipeline is dequantize (3 stages), exp(-u) by Horner steps and
// squarings (18 stages), a restoring divider of one bit per stage
// (26 stages with setup), select (1) and requantize (3).
// A stall on rsp_ready freezes the whole pipeline; req_ready drops in the
// same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with relu, zero
// points 0 and both scales 1.0. No clearing pass is needed.
`default_nettype none
module quantized_activation_int8 (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [7:0]            req_sample_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [7:0]                 rsp_sample_out,
   input  wire logic                         csr_we,
   input  wire logic [qact_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                  csr_wdata
);

   localparam int MAG_W = qact_pkg::MAG_W;
   localparam int U_W   = qact_pkg::U_W;
   localparam int T_W   = qact_pkg::T_W;
   localparam int DEN_W = qact_pkg::DEN_W;
   localparam int QUO_W = qact_pkg::QUO_W;
   localparam int NUM_W = qact_pkg::NUM_W;

   // settings registers
   logic [1:0]        mode_ff;
   logic signed [7:0] in_zp_ff;
   logic [31:0]       in_scale_ff;
   logic signed [7:0] out_zp_ff;
   logic [31:0]       out_inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= qact_pkg::MODE_RELU;
         in_zp_ff    <= '0;
         in_scale_ff <= 32'h0100_0000;
         out_zp_ff   <= '0;
         out_inv_ff  <= 32'h0001_0000;
      end else if (csr_we) begin
         unique case (csr_index)
            qact_pkg::REG_MODE:    mode_ff     <= csr_wdata[1:0];
            qact_pkg::REG_IN_ZP:   in_zp_ff    <= csr_wdata[7:0];
            qact_pkg::REG_IN_SCL:  in_scale_ff <= csr_wdata;
            qact_pkg::REG_OUT_ZP:  out_zp_ff   <= csr_wdata[7:0];
            qact_pkg::REG_OUT_INV: out_inv_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   // stage 1: subtract zero point, take magnitude
   logic             s1_v_ff;
   logic             s1_neg_ff;
   logic [7:0]       s1_abs_ff;
   logic signed [8:0] diff;
   logic [8:0]       diff_abs;

   assign diff     = 9'(req_sample_in) - 9'(in_zp_ff);
   assign diff_abs = diff[8] ? 9'(-diff) : diff;

   // stage 2: scale
   logic             s2_v_ff;
   logic             s2_neg_ff;
   logic [MAG_W-1:0] s2_m_ff;

   // stage 3: linear results and exp argument
   logic               s3_v_ff;
   qact_pkg::side_type s3_side_ff;
   logic [U_W-1:0]     s3_u_ff;
   qact_pkg::side_type side_in;
   logic [MAG_W-1:0]   tanh_m;
   logic [U_W-1:0]     u_in;

   always_comb begin
      side_in.mode = mode_ff;
      side_in.neg  = s2_neg_ff;
      if (s2_neg_ff) begin
         side_in.lin = '0;
      end else if (mode_ff == qact_pkg::MODE_RELU6 && s2_m_ff > qact_pkg::SIX_Q24) begin
         side_in.lin = qact_pkg::SIX_Q24;
      end else begin
         side_in.lin = s2_m_ff;
      end
      tanh_m = (s2_m_ff > qact_pkg::TANH_CLAMP) ? qact_pkg::TANH_CLAMP : s2_m_ff;
      if (mode_ff == qact_pkg::MODE_TANH) begin
         u_in = U_W'({tanh_m, 1'b0});
      end else if (s2_m_ff > qact_pkg::SIGM_CLAMP) begin
         u_in = U_W'(qact_pkg::SIGM_CLAMP);
      end else begin
         u_in = U_W'(s2_m_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff  <= diff[8];
         s1_abs_ff  <= diff_abs[7:0];
         s2_neg_ff  <= s1_neg_ff;
         s2_m_ff    <= MAG_W'(s1_abs_ff) * MAG_W'(in_scale_ff);
         s3_side_ff <= side_in;
         s3_u_ff    <= u_in;
      end
   end

   // exponential
   logic               exp_valid;
   qact_pkg::side_type exp_side;
   logic [T_W-1:0]     exp_e;

   qact_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_v_ff),
      .in_side   (s3_side_ff),
      .in_u      (s3_u_ff),
      .out_valid (exp_valid),
      .out_side  (exp_side),
      .out_e     (exp_e)
   );

   // divider setup
   logic               ds_v_ff;
   qact_pkg::side_type ds_side_ff;
   logic [DEN_W-1:0]   ds_rem_ff;
   logic [QUO_W-1:0]   ds_low_ff;
   logic [DEN_W-1:0]   ds_den_ff;
   logic [DEN_W-1:0]   den_in;
   logic [NUM_W-1:0]   num_in;

   always_comb begin
      den_in = DEN_W'(qact_pkg::ONE_Q30) + DEN_W'(exp_e);
      if (exp_side.mode == qact_pkg::MODE_TANH) begin
         num_in = {NUM_W'(qact_pkg::ONE_Q30 - exp_e)} << 24;
      end else begin
         num_in = NUM_W'(1) << 54;
      end
      num_in = num_in + NUM_W'(den_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_v_ff <= 1'b0;
      end else if (adv) begin
         ds_v_ff <= exp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_side_ff <= exp_side;
         ds_rem_ff  <= DEN_W'(num_in[NUM_W-1:QUO_W]);
         ds_low_ff  <= num_in[QUO_W-1:0];
         ds_den_ff  <= den_in;
      end
   end

   logic               div_valid;
   qact_pkg::side_type div_side;
   logic [QUO_W-1:0]   div_quo;

   qact_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (ds_v_ff),
      .in_side   (ds_side_ff),
      .in_rem    (ds_rem_ff),
      .in_low    (ds_low_ff),
      .in_den    (ds_den_ff),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo   (div_quo)
   );

   // select the activation result
   logic             sel_v_ff;
   logic             sel_neg_ff;
   logic [MAG_W-1:0] sel_mag_ff;
   logic [MAG_W-1:0] mag_in;

   always_comb begin
      case (div_side.mode)
         qact_pkg::MODE_TANH: mag_in = MAG_W'(div_quo);
         qact_pkg::MODE_SIGM:
            mag_in = div_side.neg ? MAG_W'(qact_pkg::ONE_Q24 - div_quo) : MAG_W'(div_quo);
         default:             mag_in = div_side.lin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
      end else if (adv) begin
         sel_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_neg_ff <= div_side.neg && (div_side.mode == qact_pkg::MODE_TANH);
         sel_mag_ff <= mag_in;
      end
   end

   qact_requant u_requant (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (sel_v_ff),
      .in_neg     (sel_neg_ff),
      .in_mag     (sel_mag_ff),
      .inv_scale  (out_inv_ff),
      .out_offset (out_zp_ff),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample_out)
   );

`ifndef ASSERT_OFF
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while result stalled");

   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      exp_valid |-> (exp_e <= qact_pkg::ONE_Q30))
      else $error("exponential above one");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (div_quo <= qact_pkg::ONE_Q24))
      else $error("quotient above one");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for quantized_activation_int8: drives int8 samples through several
// register settings and checks every response against a bit-true predictor.
// Depends on qact_pkg and the quantized_activation_int8 RTL.
`timescale 1ns / 1ps

class act_scoreboard;
   logic signed [7:0] pending[$];
   int errors;

   function void note_request(logic signed [7:0] expected);
      pending.push_back(expected);
   endfunction

   function void check_response(logic signed [7:0] got);
      logic signed [7:0] want;
      if (pending.size() == 0) begin
         report_mismatch($sformatf("unexpected response %0d", got));
      end else begin
         want = pending.pop_front();
         if (got !== want)
            report_mismatch($sformatf("sample_out got %0d want %0d", got, want));
      end
   endfunction

   function void report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endfunction
endclass

module testbench;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [7:0] req_sample_in = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [7:0] rsp_sample_out;
   logic csr_we = 0;
   logic [qact_pkg::IDX_W-1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;

   // active settings mirrored by the predictor
   logic [1:0] act_mode;
   logic signed [7:0] in_zp, out_zp;
   logic [31:0] in_scale, out_inv;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;

   act_scoreboard board = new();

   quantized_activation_int8 uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [63:0] exp_neg(logic [63:0] u);
      logic [63:0] t;
      t = 64'd1 << 30;
      for (int k = 6; k >= 1; k--)
         t = (64'd1 << 30) - ((u * t) >> 30) / k;
      for (int i = 0; i < 6; i++)
         t = (t * t + (64'd1 << 29)) >> 30;
      return t;
   endfunction

   function automatic logic signed [7:0] predict_activation(logic signed [7:0] x);
      int d, r;
      logic neg;
      logic [63:0] m, a, e, den, q, hi;
      d = int'(x) - int'(in_zp);
      neg = d < 0;
      m = 64'(neg ? -d : d) * 64'(in_scale);
      case (act_mode)
         qact_pkg::MODE_RELU: begin
            a = neg ? 0 : m;
            neg = 0;
         end
         qact_pkg::MODE_RELU6: begin
            a = neg ? 0 : (m > 64'(qact_pkg::SIX_Q24) ? 64'(qact_pkg::SIX_Q24) : m);
            neg = 0;
         end
         qact_pkg::MODE_TANH: begin
            if (m > 64'(qact_pkg::TANH_CLAMP)) m = 64'(qact_pkg::TANH_CLAMP);
            e = exp_neg(m * 2);
            den = (64'd1 << 30) + e;
            a = ((((64'd1 << 30) - e) << 24) + (den >> 1)) / den;
         end
         default: begin
            if (m > 64'(qact_pkg::SIGM_CLAMP)) m = 64'(qact_pkg::SIGM_CLAMP);
            e = exp_neg(m);
            den = (64'd1 << 30) + e;
            a = ((64'd1 << 54) + (den >> 1)) / den;
            if (neg) a = (64'd1 << 24) - a;
            neg = 0;
         end
      endcase
      hi = (a >> 24) * 64'(out_inv) + (((a & 64'hFF_FFFF) * 64'(out_inv)) >> 24);
      q = (hi + 32768) >> 16;
      if (q > 255) q = 255;
      r = neg ? -int'(q) : int'(q);
      r += int'(out_zp);
      if (r > 127) r = 127;
      if (r < -128) r = -128;
      return 8'(r);
   endfunction

   task automatic write_reg(logic [qact_pkg::IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         qact_pkg::REG_MODE:    act_mode = val[1:0];
         qact_pkg::REG_IN_ZP:   in_zp = val[7:0];
         qact_pkg::REG_IN_SCL:  in_scale = val;
         qact_pkg::REG_OUT_ZP:  out_zp = val[7:0];
         qact_pkg::REG_OUT_INV: out_inv = val;
         default: ;
      endcase
   endtask

   // drop valid and wait until every expected response is back
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic [7:0] izp, logic [31:0] isc,
                            logic [7:0] ozp, logic [31:0] oinv);
      drain();
      write_reg(qact_pkg::REG_MODE, {$urandom} & ~32'h3 | mode);  // upper bits are dropped
      write_reg(qact_pkg::REG_IN_ZP, {$urandom} & ~32'hFF | izp);
      write_reg(qact_pkg::REG_IN_SCL, isc);
      write_reg(qact_pkg::REG_OUT_ZP, ozp);
      write_reg(qact_pkg::REG_OUT_INV, oinv);
   endtask

   // valid stays high between back-to-back requests; drop it only while idling
   task automatic send_sample(logic signed [7:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(predict_activation(x));
   endtask

   // random scale: a full random word, up to 1.0, from 1/16 to 8.0, or a tiny value
   function automatic logic [31:0] pick_scale(int frac_bits);
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1, 32'd1 << frac_bits);
         2: return $urandom_range(32'd1 << (frac_bits - 4), 32'd1 << (frac_bits + 3));
         default: return $urandom_range(1, 255);
      endcase
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) board.check_response(rsp_sample_out);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      logic signed [7:0] edge_vals[8] = '{-128, -127, -1, 0, 1, 2, 126, 127};
      int wait_cycles;
      act_mode = qact_pkg::MODE_RELU; in_zp = 0; in_scale = 32'h0100_0000;
      out_zp = 0; out_inv = 32'h0001_0000;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every mode at defaults with extreme samples
      for (int md = 0; md < 4; md++) begin
         configure(2'(md), 0, 32'h0100_0000, 0, 32'h0001_0000);
         foreach (edge_vals[i]) send_sample(edge_vals[i]);
      end
      // zero scales, extreme zero points and scales
      configure(qact_pkg::MODE_TANH, 8'h80, 32'hFFFF_FFFF, 8'h7F, 0);
      send_sample(127); send_sample(-128);
      configure(qact_pkg::MODE_SIGM, 8'h7F, 0, 8'h80, 32'hFFFF_FFFF);
      send_sample(-128); send_sample(5);
      configure(qact_pkg::MODE_RELU, 8'h80, 1, 8'h80, 1);
      send_sample(127); send_sample(0);
      drain();
      write_reg(3'd5, 32'hFFFF_FFFF);  // unknown index, ignored
      write_reg(3'd7, 32'h0);
      send_sample(127);

      // random phases under the four idling profiles
      for (int ph = 0; ph < 24; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         configure(2'($urandom_range(3)), 8'($urandom), pick_scale(24),
                   8'($urandom), pick_scale(16));
         if (ph == 5) hold_off = 300;  // back up the pipeline
         for (int n = 0; n < 64; n++) send_sample(8'($urandom));
         if (ph == 9) begin
            req_valid <= 0;
            while (board.pending.size() != 0) @(posedge clock);
         end
      end

      send_idle_pct = 0;
      req_valid <= 0;
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
